// ===== rtl/core/eioc_pkg.sv =====
// shared constants and types for the ease-in/ease-out curve unit
`timescale 1ns / 1ps
`default_nettype none

package eioc_pkg;

  // q12 fixed point
  localparam int unsigned Q_W    = 13;
  localparam int unsigned FRAC_W = 12;
  localparam logic [Q_W-1:0] Q_ONE = 13'h1000;
  localparam logic [Q_W:0]   Q_TWO = 14'h2000;

  // stream data width, fields padded to whole bytes
  localparam int unsigned TDATA_W = 16;

  // shared divider: 25-bit dividend, 14-bit divisor
  localparam int unsigned DIV_NUM_W = 25;
  localparam int unsigned DIV_DEN_W = 14;
  localparam logic [DIV_NUM_W-1:0] K_NUM = 25'h1000000;

  // configuration register indexes
  localparam logic CFG_EASE_IN  = 1'b0;
  localparam logic CFG_EASE_OUT = 1'b1;

  typedef struct packed {
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/ease_in_out_curve_q12_unit.sv =====
// top level: q12 ease-in / linear / ease-out curve, four-stage pipeline
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   handshake                 payload
// s_*       in    s_tvalid / s_tready       s_tdata[12:0] time_in
// m_*       out   m_tvalid / m_tready       m_tdata[12:0] position_out
// cfg_*     in    cfg_we (no wait)          cfg_addr 0 ease_in, 1 ease_out; cfg_wdata
//
// one beat per cycle sustained while m_tready is high and no recompute runs; a result is registered
// through stages A to D (clamp/segment select, first multiply, second multiply, output register)
// each config write starts a recompute of the curve constants on one shared
// serial divider: up to five divides, while s_tready is low
// reset clears the config registers to zero and sets pass (curve is a straight pass-through)
// a stall on m_tready backs up stage by stage; bubbles are squeezed out

module ease_in_out_curve_q12_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [eioc_pkg::TDATA_W-1:0]  s_tdata,   // [12:0] time_in, [15:13] zero
  // output stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [eioc_pkg::TDATA_W-1:0]       m_tdata,   // [12:0] position_out, [15:13] zero
  // config write port
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_addr,
  input  wire logic [eioc_pkg::Q_W-1:0]      cfg_wdata
);
  import eioc_pkg::*;

  // curve segment of one sample
  typedef enum logic [1:0] {
    SEG_PASS = 2'd0,
    SEG_IN   = 2'd1,
    SEG_MID  = 2'd2,
    SEG_OUT  = 2'd3
  } seg_t;

  // constant recompute sequencer
  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_LOAD      = 7'b0000010,
    ST_SCALE_IN  = 7'b0000100,
    ST_SCALE_OUT = 7'b0001000,
    ST_K         = 7'b0010000,
    ST_A_IN      = 7'b0100000,
    ST_A_OUT     = 7'b1000000
  } seq_state_t;

  // ---------------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------------
  logic [Q_W-1:0] ease_in;
  logic [Q_W-1:0] ease_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      ease_in  <= '0;
      ease_out <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_EASE_IN:  ease_in  <= cfg_wdata;
        CFG_EASE_OUT: ease_out <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // derived constants: effective ease lengths, speed k, and the two
  // parabola gains k*4096/in and k*4096/max(out,1)
  // ---------------------------------------------------------------------------
  seq_state_t           state;
  logic                 go;
  div_req_t             div_req;
  logic                 div_done;
  logic                 div_ack;
  logic [DIV_NUM_W-1:0] div_quo;

  logic                 pass;       // ease_in + ease_out is zero
  logic [Q_W-1:0]       ein_eff;
  logic [Q_W-1:0]       eout_eff;
  logic [Q_W-1:0]       k;
  logic [DIV_NUM_W-1:0] a_in;
  logic [DIV_NUM_W-1:0] a_out;

  logic [Q_W:0]         cfg_sum;
  logic [DIV_DEN_W-1:0] eout_den;
  logic [DIV_DEN_W-1:0] k_den_scaled;

  always_comb begin
    cfg_sum      = {1'b0, ease_in} + {1'b0, ease_out};
    eout_den     = (eout_eff == '0) ? DIV_DEN_W'(1) : {1'b0, eout_eff};
    // divisor for k once ease_out has just been rescaled
    k_den_scaled = Q_TWO - {1'b0, ein_eff} - {1'b0, div_quo[Q_W-1:0]};
    // a done pulse next to a fresh start belongs to a divide cut short by a write
    div_ack      = div_done && !go;
  end

  eioc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (go),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      go    <= 1'b0;
      pass  <= 1'b1;
    end else begin
      go <= 1'b0;
      if (cfg_we) begin
        // any write restarts the whole recompute
        state <= ST_LOAD;
      end else begin
        unique case (state)
          ST_IDLE: ;
          ST_LOAD: begin
            if (cfg_sum == '0) begin
              pass  <= 1'b1;
              state <= ST_IDLE;
            end else begin
              pass <= 1'b0;
              go   <= 1'b1;
              if (cfg_sum > {1'b0, Q_ONE}) begin
                // too long: rescale both so the sum fits in one
                div_req <= '{num: {ease_in, FRAC_W'(0)}, den: cfg_sum};
                state   <= ST_SCALE_IN;
              end else begin
                ein_eff  <= ease_in;
                eout_eff <= ease_out;
                div_req  <= '{num: K_NUM, den: Q_TWO - cfg_sum};
                state    <= ST_K;
              end
            end
          end
          ST_SCALE_IN: begin
            if (div_ack) begin
              ein_eff <= div_quo[Q_W-1:0];
              div_req <= '{num: {ease_out, FRAC_W'(0)}, den: cfg_sum};
              go      <= 1'b1;
              state   <= ST_SCALE_OUT;
            end
          end
          ST_SCALE_OUT: begin
            if (div_ack) begin
              eout_eff <= div_quo[Q_W-1:0];
              div_req  <= '{num: K_NUM, den: k_den_scaled};
              go       <= 1'b1;
              state    <= ST_K;
            end
          end
          ST_K: begin
            if (div_ack) begin
              k  <= div_quo[Q_W-1:0];
              go <= 1'b1;
              if (ein_eff != '0) begin
                div_req <= '{num: {div_quo[Q_W-1:0], FRAC_W'(0)}, den: {1'b0, ein_eff}};
                state   <= ST_A_IN;
              end else begin
                // no ease-in part, its gain is never used
                div_req <= '{num: {div_quo[Q_W-1:0], FRAC_W'(0)}, den: eout_den};
                state   <= ST_A_OUT;
              end
            end
          end
          ST_A_IN: begin
            if (div_ack) begin
              a_in    <= div_quo;
              div_req <= '{num: {k, FRAC_W'(0)}, den: eout_den};
              go      <= 1'b1;
              state   <= ST_A_OUT;
            end
          end
          ST_A_OUT: begin
            if (div_ack) begin
              a_out <= div_quo;
              state <= ST_IDLE;
            end
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sample pipeline: A select, B first multiply, C second multiply, D output
  // ---------------------------------------------------------------------------
  logic va, vb, vc;
  logic en_a, en_b, en_c, en_d;

  always_comb begin
    en_d = !m_tvalid || m_tready;
    en_c = !vc || en_d;
    en_b = !vb || en_c;
    en_a = !va || en_b;
  end

  assign s_tready = en_a && (state == ST_IDLE);

  // stage A: clamp, pick segment and multiplier operands
  logic [Q_W-1:0]       t_in;
  seg_t                 seg_sel;
  logic [Q_W:0]         x_sel;
  logic [DIV_NUM_W-1:0] gain_sel;

  always_comb begin
    t_in     = (s_tdata[Q_W-1:0] > Q_ONE) ? Q_ONE : s_tdata[Q_W-1:0];
    if (pass) begin
      seg_sel = SEG_PASS;
    end else if (t_in < ein_eff) begin
      seg_sel = SEG_IN;
    end else if ({1'b0, t_in} < ({1'b0, Q_ONE} - {1'b0, eout_eff})) begin
      seg_sel = SEG_MID;
    end else begin
      seg_sel = SEG_OUT;
    end
    case (seg_sel)
      SEG_IN: begin
        x_sel    = {1'b0, t_in};
        gain_sel = a_in;
      end
      SEG_MID: begin
        // 2t - in, the linear part
        x_sel    = {t_in, 1'b0} - {1'b0, ein_eff};
        gain_sel = {(DIV_NUM_W - Q_W)'(0), k};
      end
      SEG_OUT: begin
        // time left to the end
        x_sel    = {1'b0, Q_ONE - t_in};
        gain_sel = a_out;
      end
      default: begin
        x_sel    = '0;
        gain_sel = '0;
      end
    endcase
  end

  seg_t                 seg_a;
  logic [Q_W-1:0]       t_a;
  logic [Q_W:0]         x_a;
  logic [DIV_NUM_W-1:0] gain_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en_a) begin
      va <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      seg_a  <= seg_sel;
      t_a    <= t_in;
      x_a    <= x_sel;
      gain_a <= gain_sel;
    end
  end

  // stage B: gain * x, dropped by 12 bits, clipped to 13 bits
  localparam int unsigned P1_W = DIV_NUM_W + Q_W + 1;

  logic [P1_W-1:0] p1;
  logic [Q_W-1:0]  v1_next;

  always_comb begin
    p1      = P1_W'(gain_a) * P1_W'(x_a);
    v1_next = (|p1[P1_W-1:FRAC_W+Q_W]) ? '1 : p1[FRAC_W+Q_W-1:FRAC_W];
  end

  seg_t           seg_b;
  logic [Q_W-1:0] t_b;
  logic [Q_W-1:0] x_b;
  logic [Q_W-1:0] v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      seg_b <= seg_a;
      t_b   <= t_a;
      x_b   <= x_a[Q_W-1:0];
      v1    <= v1_next;
    end
  end

  // stage C: second multiply of the parabola parts
  localparam int unsigned P2_W = FRAC_W + Q_W;

  logic [P2_W-1:0] p2;

  always_comb begin
    p2 = P2_W'(v1) * P2_W'(x_b);
  end

  seg_t           seg_c;
  logic [Q_W-1:0] t_c;
  logic [Q_W-1:0] v1_c;
  logic [Q_W-1:0] c_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en_c) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      seg_c <= seg_b;
      t_c   <= t_b;
      v1_c  <= v1;
      c_c   <= p2[P2_W-1:FRAC_W];
    end
  end

  // stage D: finish the segment and saturate into 0..one
  logic [Q_W-1:0] pos_next;
  logic [Q_W-1:0] pos;

  always_comb begin
    case (seg_c)
      SEG_IN:  pos_next = (c_c > Q_ONE) ? Q_ONE : c_c;
      SEG_MID: pos_next = (v1_c > Q_ONE) ? Q_ONE : v1_c;
      SEG_OUT: pos_next = (c_c > Q_ONE) ? '0 : Q_ONE - c_c;
      default: pos_next = t_c;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_d) begin
      m_tvalid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      pos <= pos_next;
    end
  end

  assign m_tdata = {(TDATA_W - Q_W)'(0), pos};

endmodule

`default_nettype wire

// ===== rtl/core/eioc_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module eioc_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire eioc_pkg::div_req_t             req,
  output logic                                done,
  output logic [eioc_pkg::DIV_NUM_W-1:0]      quo
);
  import eioc_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_NUM_W-1:0] q;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  always_comb begin
    trial = {rem, q[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den};
    ge    = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        den  <= req.den;
        q    <= req.num;
      end else if (busy) begin
        rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        q   <= {q[DIV_NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;

endmodule

`default_nettype wire

// ===== tb/ease_curve_checker.sv =====
// stream checker for the q12 ease curve: predicts each position and compares it with the output beat
`timescale 1ns / 1ps

module ease_curve_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  input  wire logic                          s_tready,
  input  wire logic [eioc_pkg::TDATA_W-1:0]  s_tdata,   // [12:0] time_in, [15:13] zero
  input  wire logic                          m_tvalid,
  input  wire logic                          m_tready,
  input  wire logic [eioc_pkg::TDATA_W-1:0]  m_tdata,   // [12:0] position_out, [15:13] zero
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_addr,
  input  wire logic [eioc_pkg::Q_W-1:0]      cfg_wdata,
  output int                                 fail_count,
  output int                                 outstanding
);

  localparam longint unsigned ONE  = eioc_pkg::Q_ONE;
  localparam longint unsigned TWO  = eioc_pkg::Q_TWO;
  localparam longint unsigned KNUM = eioc_pkg::K_NUM;

  typedef struct packed {
    logic [12:0] time_in;
    logic [12:0] position;
  } sample_t;

  logic [12:0] ease_in_copy;
  logic [12:0] ease_out_copy;
  sample_t     pending_positions[$];
  int          errors;

  // position for one time sample under the given ease lengths, all divisions truncate
  function automatic logic [12:0] eased_position(input logic [12:0] t_raw,
                                                 input logic [12:0] in_reg,
                                                 input logic [12:0] out_reg);
    longint unsigned t, ein, eout, span, k, a, b, c, u, e, mid;
    t    = t_raw;
    ein  = in_reg;
    eout = out_reg;
    if (t > ONE) t = ONE;
    span = ein + eout;
    if (span == 0) return t[12:0];
    // too much easing: shrink both so they fit in one unit of time
    if (span > ONE) begin
      ein  = (ein * ONE) / span;
      eout = (eout * ONE) / span;
    end
    k = KNUM / (TWO - ein - eout);
    if (t < ein) begin
      a = (k * ONE) / ein;
      b = (a * t) / ONE;
      c = (b * t) / ONE;
      if (c > ONE) c = ONE;
      return c[12:0];
    end
    if (t < ONE - eout) begin
      mid = (t * TWO) / ONE - ein;
      c   = (k * mid) / ONE;
      if (c > ONE) c = ONE;
      return c[12:0];
    end
    // deceleration tail, a zero ease_out divides by one
    u = ONE - t;
    e = (eout == 0) ? 1 : eout;
    a = (k * ONE) / e;
    b = (a * u) / ONE;
    c = (b * u) / ONE;
    if (c > ONE) return '0;
    c = ONE - c;
    return c[12:0];
  endfunction

  function automatic void note_failure(input string what, input sample_t want,
                                       input logic [12:0] got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s time_in=%0d expected position=%0d got %0d",
               $realtime, what, want.time_in, want.position, got);
  endfunction

  always @(posedge clk) begin
    sample_t want;
    if (rst) begin
      ease_in_copy  <= '0;
      ease_out_copy <= '0;
      pending_positions.delete();
      errors = 0;
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          eioc_pkg::CFG_EASE_IN:  ease_in_copy  <= cfg_wdata;
          eioc_pkg::CFG_EASE_OUT: ease_out_copy <= cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        want.time_in  = s_tdata[12:0];
        want.position = eased_position(s_tdata[12:0], ease_in_copy, ease_out_copy);
        pending_positions.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (pending_positions.size() == 0) begin
          want = '0;
          note_failure("unexpected beat", want, m_tdata[12:0]);
        end else begin
          want = pending_positions.pop_front();
          if (m_tdata[12:0] !== want.position)
            note_failure("position mismatch", want, m_tdata[12:0]);
        end
      end
      fail_count  <= errors;
      outstanding <= pending_positions.size();
    end
  end

endmodule

// ===== tb/ease_in_out_curve_q12_unit_tb.sv =====
// testbench top for the q12 ease curve unit: stimulus, config phases and the verdict
`timescale 1ns / 1ps

module ease_in_out_curve_q12_unit_tb;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [eioc_pkg::TDATA_W-1:0]  s_tdata;    // [12:0] time_in, [15:13] zero
  logic                          m_tvalid;
  logic                          m_tready;
  logic [eioc_pkg::TDATA_W-1:0]  m_tdata;    // [12:0] position_out, [15:13] zero
  logic                          cfg_we;
  logic                          cfg_addr;
  logic [eioc_pkg::Q_W-1:0]      cfg_wdata;

  int   fail_count;
  int   outstanding;
  // when set, both sides run back to back with no idle cycles
  logic steady = 1'b0;
  // raw register values, used only to aim time samples at segment borders
  int unsigned cur_in;
  int unsigned cur_out;

  ease_in_out_curve_q12_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  ease_curve_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // safety net in case a handshake never completes
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // output side: random stall before each beat, held ready until the beat goes through
  initial begin
    int unsigned stall;
    m_tready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // one input beat; valid stays high across back-to-back beats
  task automatic send_time(input logic [12:0] t);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, t};
    do @(posedge clk); while (!s_tready);
  endtask

  // hold the input side until every predicted position has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // register write, then wait out the constant recompute (s_tready low meanwhile)
  task automatic write_reg(input logic addr, input logic [12:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    // give the recompute time to pull s_tready down before polling it
    repeat (4) @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic set_easing(input logic [12:0] ein, input logic [12:0] eout);
    wait_drained();
    write_reg(eioc_pkg::CFG_EASE_IN, ein);
    write_reg(eioc_pkg::CFG_EASE_OUT, eout);
    cur_in  = ein;
    cur_out = eout;
  endtask

  // ease length: mostly inside one unit, with zero, full, oversize and tiny values mixed in
  function automatic logic [12:0] pick_ease();
    case ($urandom_range(0, 7))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'd8191;
      3: return 13'($urandom_range(0, 8191));
      4: return 13'($urandom_range(1, 16));
      default: return 13'($urandom_range(0, 2048));
    endcase
  endfunction

  // time sample: mostly in range, some clamped, some at the segment borders
  function automatic logic [12:0] pick_time();
    int signed t;
    case ($urandom_range(0, 9))
      0: t = $urandom_range(0, 8191);
      1: case ($urandom_range(0, 3))
           0: t = 0;
           1: t = 1;
           2: t = 4095;
           default: t = 4096;
         endcase
      2: t = int'(cur_in) + int'($urandom_range(0, 2)) - 1;
      3: t = 4096 - int'(cur_out) + int'($urandom_range(0, 2)) - 1;
      default: t = $urandom_range(0, 4096);
    endcase
    if (t < 0) t = 0;
    if (t > 8191) t = 8191;
    return 13'(t);
  endfunction

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned which;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= eioc_pkg::CFG_EASE_IN;
    cfg_wdata <= '0;
    cur_in  = 0;
    cur_out = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // straight pass-through out of reset, including a clamped time
    send_time(13'd0);
    send_time(13'd1);
    send_time(13'd4096);
    send_time(13'd8191);

    // all three segments and both borders
    set_easing(13'd1024, 13'd1024);
    send_time(13'd0);
    send_time(13'd1);
    send_time(13'd1023);
    send_time(13'd1024);
    send_time(13'd2048);
    send_time(13'd3071);
    send_time(13'd3072);
    send_time(13'd4095);
    send_time(13'd4096);

    // no acceleration, the whole curve decelerating
    set_easing(13'd0, 13'd4096);
    send_time(13'd0);
    send_time(13'd2048);
    send_time(13'd4096);

    // full acceleration, ease_out zero so the tail divides by one
    set_easing(13'd4096, 13'd0);
    send_time(13'd0);
    send_time(13'd4095);
    send_time(13'd4096);

    // both at the register maximum, rescaled down to half each
    set_easing(13'd8191, 13'd8191);
    send_time(13'd1);
    send_time(13'd2048);
    send_time(13'd4095);

    // random phases of 50 beats, new ease lengths between phases
    for (phase = 0; phase < 27; phase++) begin
      wait_drained();
      which = $urandom_range(0, 3);
      if (which != 1) begin
        cur_in = pick_ease();
        write_reg(eioc_pkg::CFG_EASE_IN, 13'(cur_in));
      end
      if (which != 0) begin
        cur_out = pick_ease();
        write_reg(eioc_pkg::CFG_EASE_OUT, 13'(cur_out));
      end
      steady = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 50; n++) begin
        send_time(pick_time());
        // mid-phase drain: input waits for the pipeline to empty completely
        if (phase == 13 && n == 24) wait_drained();
      end
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/eioc_pkg.sv
rtl/core/eioc_div.sv
rtl/core/ease_in_out_curve_q12_unit.sv
tb/ease_curve_checker.sv
tb/ease_in_out_curve_q12_unit_tb.sv
